/* design/pcsq_pkg.sv */
// Shared types and constants for the PC sequencer and special register file.
// Holds request and status codes, special register addresses and reset values.
// No dependencies.
`timescale 1ns / 1ps

package pcsq_pkg;

    // General register file size and the index bits that address it
    localparam int unsigned NUM_GPRS = 32;
    localparam int unsigned GPR_AW   = (NUM_GPRS > 1) ? $clog2(NUM_GPRS) : 1;
    localparam int unsigned IDX_W    = 5;

    // Request kinds carried in the input tuser
    typedef enum logic [2:0] {
        REQ_SOFT_RESET = 3'd0,
        REQ_ADVANCE    = 3'd1,
        REQ_SET_BRANCH = 3'd2,
        REQ_WRITE_GPR  = 3'd3,
        REQ_READ_GPR   = 3'd4,
        REQ_WRITE_SPR  = 3'd5,
        REQ_READ_SPR   = 3'd6
    } t_req;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SPR  = 2'd1,
        ST_NO_SUPER = 2'd2
    } t_status;

    // Special register addresses
    typedef enum logic [15:0] {
        SPR_NPC        = 16'h0010,
        SPR_SR         = 16'h0011,
        SPR_PPC        = 16'h0012,
        SPR_EPCR       = 16'h0020,
        SPR_EEAR       = 16'h0030,
        SPR_ESR        = 16'h0040,
        SPR_MAC_LO     = 16'h2801,
        SPR_MAC_HI     = 16'h2802,
        SPR_TICK_MODE  = 16'h5000,
        SPR_TICK_COUNT = 16'h5001
    } t_spr_addr;

    localparam logic [31:0] NO_BRANCH = 32'hffff_ffff;
    localparam logic [31:0] SR_WMASK  = 32'hf001_ffff;
    localparam logic [31:0] SR_FORCE  = 32'h0000_8000;
    localparam logic [31:0] SR_RESET  = 32'h0000_8001;
    localparam logic [31:0] PC_RESET  = 32'h0000_0100;
    localparam logic [31:0] NPC_RESET = 32'h0000_0104;
    localparam logic [31:0] PC_STEP   = 32'h0000_0004;
    localparam int unsigned SR_SUPER_BIT = 0;

endpackage

/* design/pc_sequencer_and_spr_file_core.sv */
// PC sequencer with general and special register file, one request per word.
// Depends on pcsq_pkg for codes, addresses and reset values.
//
//  channel | direction | tdata (low bit up)                        | tuser
//  --------+-----------+-------------------------------------------+-------------
//  s       | in        | reg_index 5, spr_addr 16, write_value 32  | req_type 3
//  m       | out       | read_data 32, cur_pc 32, next_pc 32       | status 2
//
// A word is held in the input register, then decoded, applied to the state and
// loaded into the result register. A new word is taken every cycle while the
// reply side keeps taking results; that rate is set by the single decode-and-mux pass between the two registers.
// While the result register is full and not taken, the input register holds and
// o_s_tready drops once it is also full. Synchronous reset loads the
// architectural reset values and empties both registers.
`timescale 1ns / 1ps

module pc_sequencer_and_spr_file_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [55:0]  i_s_tdata,   // reg_index[4:0], spr_addr[20:5], write_value[52:21]
    input  logic [2:0]   i_s_tuser,   // req_type[2:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,   // read_data[31:0], cur_pc[63:32], next_pc[95:64]
    output logic [1:0]   o_m_tuser    // status[1:0]
);

    // Input register
    logic                           r_in_valid;
    logic [2:0]                     r_in_req;
    logic [pcsq_pkg::IDX_W-1:0]     r_in_idx;
    logic [15:0]                    r_in_addr;
    logic [31:0]                    r_in_val;

    // Result register
    logic                           r_out_valid;
    logic [31:0]                    r_out_rd;
    logic [1:0]                     r_out_st;
    logic [31:0]                    r_out_pc;
    logic [31:0]                    r_out_npc;

    // Architectural state
    logic [31:0] r_gpr [pcsq_pkg::NUM_GPRS];
    logic [31:0] r_pc, r_npc, r_branch, r_sr, r_epcr, r_eear, r_esr;
    logic [31:0] r_maclo, r_machi, r_ttmr, r_ttcr;

    logic [31:0] n_gpr [pcsq_pkg::NUM_GPRS];
    logic [31:0] n_pc, n_npc, n_branch, n_sr, n_epcr, n_eear, n_esr;
    logic [31:0] n_maclo, n_machi, n_ttmr, n_ttcr;
    logic [31:0] n_rd;
    pcsq_pkg::t_status n_st;

    logic        process;
    logic        idx_in_range;
    logic [pcsq_pkg::GPR_AW-1:0] gpr_sel;
    logic [31:0] spr_rdata;
    logic        spr_known;

    // Advance when the result register is free or being taken
    assign process    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || process;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_npc, r_out_pc, r_out_rd};
    assign o_m_tuser  = r_out_st;

    // Range check and array index for the general register file
    assign idx_in_range = ({1'b0, r_in_idx} < (pcsq_pkg::IDX_W + 1)'(pcsq_pkg::NUM_GPRS));
    assign gpr_sel      = pcsq_pkg::GPR_AW'(r_in_idx);

    // Decode the special register address for reads
    always_comb begin
        spr_known = 1'b1;
        spr_rdata = '0;
        unique case (pcsq_pkg::t_spr_addr'(r_in_addr))
            pcsq_pkg::SPR_NPC:        spr_rdata = r_npc;
            pcsq_pkg::SPR_SR:         spr_rdata = r_sr;
            pcsq_pkg::SPR_PPC:        spr_rdata = r_pc;
            pcsq_pkg::SPR_EPCR:       spr_rdata = r_epcr;
            pcsq_pkg::SPR_EEAR:       spr_rdata = r_eear;
            pcsq_pkg::SPR_ESR:        spr_rdata = r_esr;
            pcsq_pkg::SPR_MAC_LO:     spr_rdata = r_maclo;
            pcsq_pkg::SPR_MAC_HI:     spr_rdata = r_machi;
            pcsq_pkg::SPR_TICK_MODE:  spr_rdata = r_ttmr;
            pcsq_pkg::SPR_TICK_COUNT: spr_rdata = r_ttcr;
            default:                  spr_known = 1'b0;
        endcase
    end

    // Work out the new state and the result for the word in the input register
    always_comb begin
        n_gpr    = r_gpr;
        n_pc     = r_pc;
        n_npc    = r_npc;
        n_branch = r_branch;
        n_sr     = r_sr;
        n_epcr   = r_epcr;
        n_eear   = r_eear;
        n_esr    = r_esr;
        n_maclo  = r_maclo;
        n_machi  = r_machi;
        n_ttmr   = r_ttmr;
        n_ttcr   = r_ttcr;
        n_rd     = '0;
        n_st     = pcsq_pkg::ST_OK;

        unique case (r_in_req) inside
            pcsq_pkg::REQ_SOFT_RESET: begin
                for (int i = 0; i < pcsq_pkg::NUM_GPRS; i++) begin
                    n_gpr[i] = '0;
                end
                n_sr    = pcsq_pkg::SR_RESET;
                n_maclo = '0;
                n_machi = '0;
                n_pc    = pcsq_pkg::PC_RESET;
                n_npc   = pcsq_pkg::NPC_RESET;
            end
            pcsq_pkg::REQ_ADVANCE: begin
                n_pc = r_npc;
                if (r_branch != pcsq_pkg::NO_BRANCH) begin
                    n_npc    = r_branch;
                    n_branch = pcsq_pkg::NO_BRANCH;
                end else begin
                    n_npc = r_npc + pcsq_pkg::PC_STEP;
                end
            end
            pcsq_pkg::REQ_SET_BRANCH: begin
                n_branch = r_in_val;
            end
            pcsq_pkg::REQ_WRITE_GPR: begin
                // drop writes to register zero and beyond the file
                if (idx_in_range && r_in_idx != '0) begin
                    n_gpr[gpr_sel] = r_in_val;
                end
            end
            pcsq_pkg::REQ_READ_GPR: begin
                if (idx_in_range && r_in_idx != '0) begin
                    n_rd = r_gpr[gpr_sel];
                end
            end
            pcsq_pkg::REQ_WRITE_SPR,
            pcsq_pkg::REQ_READ_SPR: begin
                // supervisor check comes before the address decode
                if (!r_sr[pcsq_pkg::SR_SUPER_BIT]) begin
                    n_st = pcsq_pkg::ST_NO_SUPER;
                end else if (!spr_known) begin
                    n_st = pcsq_pkg::ST_BAD_SPR;
                end else if (r_in_req == pcsq_pkg::REQ_READ_SPR) begin
                    n_rd = spr_rdata;
                end else begin
                    case (pcsq_pkg::t_spr_addr'(r_in_addr))
                        pcsq_pkg::SPR_NPC:        n_npc   = r_in_val;
                        pcsq_pkg::SPR_SR:         n_sr    = (r_in_val & pcsq_pkg::SR_WMASK)
                                                            | pcsq_pkg::SR_FORCE;
                        pcsq_pkg::SPR_PPC:        n_pc    = r_in_val;
                        pcsq_pkg::SPR_EPCR:       n_epcr  = r_in_val;
                        pcsq_pkg::SPR_EEAR:       n_eear  = r_in_val;
                        pcsq_pkg::SPR_ESR:        n_esr   = r_in_val;
                        pcsq_pkg::SPR_MAC_LO:     n_maclo = r_in_val;
                        pcsq_pkg::SPR_MAC_HI:     n_machi = r_in_val;
                        pcsq_pkg::SPR_TICK_MODE:  n_ttmr  = r_in_val;
                        pcsq_pkg::SPR_TICK_COUNT: n_ttcr  = r_in_val;
                        default:                  n_ttcr  = r_ttcr;
                    endcase
                end
            end
            default: begin
                // unused request kind: ignore
            end
        endcase
    end

    // Input register: load on accept, empty when processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_req  <= i_s_tuser[2:0];
            r_in_idx  <= i_s_tdata[4:0];
            r_in_addr <= i_s_tdata[20:5];
            r_in_val  <= i_s_tdata[52:21];
        end
    end

    // Result register: load when a word is processed, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_out_rd  <= n_rd;
            r_out_st  <= n_st;
            r_out_pc  <= n_pc;
            r_out_npc <= n_npc;
        end
    end

    // Architectural state: commit only for a processed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pcsq_pkg::NUM_GPRS; i++) begin
                r_gpr[i] <= '0;
            end
            r_pc     <= pcsq_pkg::PC_RESET;
            r_npc    <= pcsq_pkg::NPC_RESET;
            r_branch <= pcsq_pkg::NO_BRANCH;
            r_sr     <= pcsq_pkg::SR_RESET;
            r_epcr   <= '0;
            r_eear   <= '0;
            r_esr    <= '0;
            r_maclo  <= '0;
            r_machi  <= '0;
            r_ttmr   <= '0;
            r_ttcr   <= '0;
        end else if (process) begin
            r_gpr    <= n_gpr;
            r_pc     <= n_pc;
            r_npc    <= n_npc;
            r_branch <= n_branch;
            r_sr     <= n_sr;
            r_epcr   <= n_epcr;
            r_eear   <= n_eear;
            r_esr    <= n_esr;
            r_maclo  <= n_maclo;
            r_machi  <= n_machi;
            r_ttmr   <= n_ttmr;
            r_ttcr   <= n_ttcr;
        end
    end

endmodule

/* bench/pc_sequencer_and_spr_file_core_tb.sv */
// Self-checking testbench for pc_sequencer_and_spr_file_core.
// It predicts every reply word from its own copy of the architectural state.
// It depends on pcsq_pkg for request codes, status codes and special register addresses.
`timescale 1ns / 1ps

module pc_sequencer_and_spr_file_core_tb;

    // Request code with no meaning; the block must ignore it
    localparam logic [2:0] REQ_UNUSED     = 3'd7;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [31:0]       read_data;
        pcsq_pkg::t_status status;
        logic [31:0]       cur_pc;
        logic [31:0]       next_pc;
    } t_result;

    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [55:0]  i_s_tdata  = '0;   // reg_index[4:0], spr_addr[20:5], write_value[52:21]
    logic [2:0]   i_s_tuser  = '0;   // req_type[2:0]
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b1;
    logic [95:0]  o_m_tdata;         // read_data[31:0], cur_pc[63:32], next_pc[95:64]
    logic [1:0]   o_m_tuser;         // status[1:0]

    // Architectural state as the bench sees it
    logic [31:0]  arch_gpr [pcsq_pkg::NUM_GPRS];
    logic [31:0]  arch_pc;
    logic [31:0]  arch_npc;
    logic [31:0]  arch_branch;
    logic [31:0]  arch_sr;
    logic [31:0]  arch_epcr;
    logic [31:0]  arch_eear;
    logic [31:0]  arch_esr;
    logic [31:0]  arch_maclo;
    logic [31:0]  arch_machi;
    logic [31:0]  arch_ttmr;
    logic [31:0]  arch_ttcr;

    t_result      reg_file_replies [$];
    logic [15:0]  spr_list [0:9];
    int unsigned  fail_count   = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  stall_left   = 0;
    bit           idle_on      = 1'b1;

    pc_sequencer_and_spr_file_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Clear what a soft reset clears; branch slot and exception registers stay
    function automatic void soft_reset_arch();
        for (int unsigned k = 0; k < pcsq_pkg::NUM_GPRS; k++) begin
            arch_gpr[k] = '0;
        end
        arch_sr    = pcsq_pkg::SR_RESET;
        arch_maclo = '0;
        arch_machi = '0;
        arch_pc    = pcsq_pkg::PC_RESET;
        arch_npc   = pcsq_pkg::NPC_RESET;
    endfunction

    // Apply one request to the architectural state and form its reply word
    function automatic t_result execute_request(logic [2:0] req, logic [4:0] idx,
                                                logic [15:0] addr, logic [31:0] val);
        t_result     r;
        logic        known;
        logic [31:0] spr_val;
        r.read_data = '0;
        r.status    = pcsq_pkg::ST_OK;
        known       = 1'b1;
        spr_val     = '0;
        case (req) inside
            pcsq_pkg::REQ_SOFT_RESET: soft_reset_arch();
            pcsq_pkg::REQ_ADVANCE: begin
                arch_pc = arch_npc;
                if (arch_branch != pcsq_pkg::NO_BRANCH) begin
                    arch_npc    = arch_branch;
                    arch_branch = pcsq_pkg::NO_BRANCH;
                end else begin
                    arch_npc = arch_npc + pcsq_pkg::PC_STEP;
                end
            end
            pcsq_pkg::REQ_SET_BRANCH: arch_branch = val;
            pcsq_pkg::REQ_WRITE_GPR: begin
                if (idx != 0 && idx < pcsq_pkg::NUM_GPRS) arch_gpr[idx] = val;
            end
            pcsq_pkg::REQ_READ_GPR: begin
                if (idx != 0 && idx < pcsq_pkg::NUM_GPRS) r.read_data = arch_gpr[idx];
            end
            pcsq_pkg::REQ_WRITE_SPR, pcsq_pkg::REQ_READ_SPR: begin
                // Supervisor check comes before the address decode
                if (!arch_sr[pcsq_pkg::SR_SUPER_BIT]) begin
                    r.status = pcsq_pkg::ST_NO_SUPER;
                end else begin
                    case (addr)
                        pcsq_pkg::SPR_NPC:        spr_val = arch_npc;
                        pcsq_pkg::SPR_SR:         spr_val = arch_sr;
                        pcsq_pkg::SPR_PPC:        spr_val = arch_pc;
                        pcsq_pkg::SPR_EPCR:       spr_val = arch_epcr;
                        pcsq_pkg::SPR_EEAR:       spr_val = arch_eear;
                        pcsq_pkg::SPR_ESR:        spr_val = arch_esr;
                        pcsq_pkg::SPR_MAC_LO:     spr_val = arch_maclo;
                        pcsq_pkg::SPR_MAC_HI:     spr_val = arch_machi;
                        pcsq_pkg::SPR_TICK_MODE:  spr_val = arch_ttmr;
                        pcsq_pkg::SPR_TICK_COUNT: spr_val = arch_ttcr;
                        default:                  known   = 1'b0;
                    endcase
                    if (!known) begin
                        r.status = pcsq_pkg::ST_BAD_SPR;
                    end else if (req == pcsq_pkg::REQ_READ_SPR) begin
                        r.read_data = spr_val;
                    end else begin
                        case (addr)
                            pcsq_pkg::SPR_NPC:        arch_npc   = val;
                            pcsq_pkg::SPR_SR:         arch_sr    = (val & pcsq_pkg::SR_WMASK)
                                                                   | pcsq_pkg::SR_FORCE;
                            pcsq_pkg::SPR_PPC:        arch_pc    = val;
                            pcsq_pkg::SPR_EPCR:       arch_epcr  = val;
                            pcsq_pkg::SPR_EEAR:       arch_eear  = val;
                            pcsq_pkg::SPR_ESR:        arch_esr   = val;
                            pcsq_pkg::SPR_MAC_LO:     arch_maclo = val;
                            pcsq_pkg::SPR_MAC_HI:     arch_machi = val;
                            pcsq_pkg::SPR_TICK_MODE:  arch_ttmr  = val;
                            pcsq_pkg::SPR_TICK_COUNT: arch_ttcr  = val;
                            default:                  known      = 1'b0;
                        endcase
                    end
                end
            end
            default: ;
        endcase
        r.cur_pc  = arch_pc;
        r.next_pc = arch_npc;
        return r;
    endfunction

    // Offer one request word, with an occasional idle burst ahead of it
    task automatic send_word(input logic [2:0] req, input logic [4:0] idx,
                             input logic [15:0] addr, input logic [31:0] val);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {3'b000, val, addr, idx};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // Register zero and the top register at their extreme values
    task automatic test_gpr_access();
        send_word(pcsq_pkg::REQ_WRITE_GPR, 5'd0, 16'h0000, 32'hffff_ffff);
        send_word(pcsq_pkg::REQ_READ_GPR, 5'd0, 16'hffff, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_WRITE_GPR, 5'd31, 16'hffff, 32'hffff_ffff);
        send_word(pcsq_pkg::REQ_READ_GPR, 5'd31, 16'h0000, 32'hffff_ffff);
    endtask

    // SR masking, PPC aliasing the PC, unknown addresses
    task automatic test_spr_access();
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, pcsq_pkg::SPR_SR, 32'hffff_ffff);
        send_word(pcsq_pkg::REQ_READ_SPR, 5'd0, pcsq_pkg::SPR_SR, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, pcsq_pkg::SPR_PPC, 32'hffff_fffc);
        send_word(pcsq_pkg::REQ_READ_SPR, 5'd0, pcsq_pkg::SPR_NPC, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_READ_SPR, 5'd0, 16'hffff, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, 16'h0000, 32'hffff_ffff);
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, pcsq_pkg::SPR_MAC_HI, 32'hffff_ffff);
    endtask

    // NPC wrap, a taken branch, and an all-ones target that clears the slot
    task automatic test_branch_sequencing();
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, pcsq_pkg::SPR_NPC, 32'hffff_fffc);
        send_word(pcsq_pkg::REQ_ADVANCE, 5'd0, 16'h0000, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_SET_BRANCH, 5'd0, 16'h0000, 32'h0000_2000);
        send_word(pcsq_pkg::REQ_ADVANCE, 5'd0, 16'h0000, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_SET_BRANCH, 5'd0, 16'h0000, pcsq_pkg::NO_BRANCH);
        send_word(pcsq_pkg::REQ_ADVANCE, 5'd0, 16'h0000, 32'h0000_0000);
    endtask

    // Drop supervisor mode, hit the lockout, then recover through soft reset
    task automatic test_supervisor_lockout();
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, pcsq_pkg::SPR_SR, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_READ_SPR, 5'd0, pcsq_pkg::SPR_SR, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_WRITE_SPR, 5'd0, 16'hffff, 32'h1234_5678);
        send_word(REQ_UNUSED, 5'd31, 16'hffff, 32'hffff_ffff);
        send_word(pcsq_pkg::REQ_SET_BRANCH, 5'd0, 16'h0000, 32'h0000_4000);
        send_word(pcsq_pkg::REQ_SOFT_RESET, 5'd0, 16'h0000, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_ADVANCE, 5'd0, 16'h0000, 32'h0000_0000);
        send_word(pcsq_pkg::REQ_READ_SPR, 5'd0, pcsq_pkg::SPR_SR, 32'h0000_0000);
    endtask

    // Weighted random requests, mostly aimed at known special registers
    task automatic test_random_traffic(input int unsigned n_words);
        logic [2:0]  req;
        logic [4:0]  idx;
        logic [15:0] addr;
        logic [31:0] val;
        int unsigned pick;
        for (int unsigned k = 0; k < n_words; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2)       req = pcsq_pkg::REQ_SOFT_RESET;
            else if (pick < 22) req = pcsq_pkg::REQ_ADVANCE;
            else if (pick < 32) req = pcsq_pkg::REQ_SET_BRANCH;
            else if (pick < 47) req = pcsq_pkg::REQ_WRITE_GPR;
            else if (pick < 62) req = pcsq_pkg::REQ_READ_GPR;
            else if (pick < 79) req = pcsq_pkg::REQ_WRITE_SPR;
            else if (pick < 97) req = pcsq_pkg::REQ_READ_SPR;
            else                req = REQ_UNUSED;
            idx  = 5'($urandom_range(0, 31));
            addr = ($urandom_range(0, 6) == 0) ? 16'($urandom) : spr_list[$urandom_range(0, 9)];
            pick = $urandom_range(0, 9);
            val  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : 32'($urandom);
            if (req == pcsq_pkg::REQ_SET_BRANCH && $urandom_range(0, 5) == 0)
                val = pcsq_pkg::NO_BRANCH;
            // Keep supervisor mode most of the time so special accesses get through
            if (req == pcsq_pkg::REQ_WRITE_SPR && addr == pcsq_pkg::SPR_SR &&
                $urandom_range(0, 4) != 0)
                val[pcsq_pkg::SR_SUPER_BIT] = 1'b1;
            send_word(req, idx, addr, val);
        end
    endtask

    // Stall the reply side in random bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 11);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Check each reply word against the oldest prediction, then predict new requests
    always @(posedge i_clk) begin : reply_monitor
        t_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (reg_file_replies.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected reply word: tdata %h status %0d",
                                 o_m_tdata, o_m_tuser);
                end else begin
                    want = reg_file_replies.pop_front();
                    if (o_m_tdata[31:0] !== want.read_data || o_m_tuser !== want.status ||
                        o_m_tdata[63:32] !== want.cur_pc || o_m_tdata[95:64] !== want.next_pc)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"mismatch (exp/got): read_data %h/%h status %0d/%0d ",
                                      "cur_pc %h/%h next_pc %h/%h"},
                                     want.read_data, o_m_tdata[31:0], want.status, o_m_tuser,
                                     want.cur_pc, o_m_tdata[63:32],
                                     want.next_pc, o_m_tdata[95:64]);
                    end
                end
            end
            if (i_s_tvalid && o_s_tready)
                reg_file_replies.push_back(execute_request(i_s_tuser, i_s_tdata[4:0],
                                                           i_s_tdata[20:5], i_s_tdata[52:21]));
        end
    end

    // End the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        spr_list = '{pcsq_pkg::SPR_NPC, pcsq_pkg::SPR_SR, pcsq_pkg::SPR_PPC,
                     pcsq_pkg::SPR_EPCR, pcsq_pkg::SPR_EEAR, pcsq_pkg::SPR_ESR,
                     pcsq_pkg::SPR_MAC_LO, pcsq_pkg::SPR_MAC_HI,
                     pcsq_pkg::SPR_TICK_MODE, pcsq_pkg::SPR_TICK_COUNT};
        // Power-on state
        soft_reset_arch();
        arch_branch = pcsq_pkg::NO_BRANCH;
        arch_epcr   = '0;
        arch_eear   = '0;
        arch_esr    = '0;
        arch_ttmr   = '0;
        arch_ttcr   = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_gpr_access();
        test_spr_access();
        test_branch_sequencing();
        test_supervisor_lockout();
        test_random_traffic(900);
        idle_on = 1'b0;
        test_random_traffic(150);
        i_s_tvalid <= 1'b0;

        // Drain, then give any stray word time to show up
        while (reg_file_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && reg_file_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
design/pcsq_pkg.sv
design/pc_sequencer_and_spr_file_core.sv
bench/pc_sequencer_and_spr_file_core_tb.sv
